@@ sv/neighbor_cutoff_list_builder_unit_macros.svh @@
// assertion macros for the neighbor list builder
`ifndef NEIGHBOR_CUTOFF_LIST_BUILDER_UNIT_MACROS_SVH
`define NEIGHBOR_CUTOFF_LIST_BUILDER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NCL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define NCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define NCL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define NCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ sv/ncl_pkg.sv @@
// ----------------------------------------------------------------------------
// ncl_pkg
// shared types and constants of the neighbor list builder
// ----------------------------------------------------------------------------
`default_nettype none
package ncl_pkg;
  localparam int unsigned AtomSlots = 4096;
  localparam int unsigned CutBits = 62;
  localparam int unsigned MaxBits = 16;
  localparam int unsigned PosBits = 28;
  localparam int unsigned DsqBits = 64;
  localparam int unsigned DistBits = 32;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BEGIN = 2'd1,
    OP_TEST  = 2'd2,
    OP_END   = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_CUTOFF = 1'b0,
    REG_MAX    = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_SQR, ST_SUM, ST_ROOT, ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic latch_center;
    logic sqr;
    logic sum;
    logic root_start;
    logic emit_entry;
    logic emit_end;
    logic count_incr;
    logic set_overflow;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic in_range;
    logic room;
    logic root_done;
  } stat_t;
endpackage
`default_nettype wire

@@ sv/neighbor_cutoff_list_builder_unit.sv @@
// ----------------------------------------------------------------------------
// neighbor_cutoff_list_builder_unit
// cutoff neighbor list builder: atom table, center latch, distance test
// ----------------------------------------------------------------------------
// write: done without going busy; begin: READ state only; end: READ then EMIT,
// result strobe registered from EMIT; test: READ, SQR, SUM, ROOT, EMIT with an
// entry, ROOT waiting on the 2-bit-per-cycle square root; back to idle from ROOT when out of range or dropped
// one item at a time; busy high while an item is in work
// rst_ni clears control state, cutoff 0, limit 256; table contents undefined
// results are strobed one cycle, the receiver cannot stall
`default_nettype none
`include "neighbor_cutoff_list_builder_unit_macros.svh"
module neighbor_cutoff_list_builder_unit #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  logic [1:0] opcode_i,
  input  logic [11:0] atom_index_i,
  input  logic [31:0] atom_tag_i,
  input  logic [3:0] atom_kind_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] charge_i,
  input  logic cfg_we_i,
  input  logic cfg_index_i,
  input  logic [ncl_pkg::CutBits-1:0] cfg_data_i,
  output logic result_valid_o,
  output logic record_kind_o,
  output logic [27:0] list_position_o,
  output logic [11:0] neighbor_index_o,
  output logic [31:0] distance_o,
  output logic signed [31:0] offset_x_o,
  output logic signed [31:0] offset_y_o,
  output logic signed [31:0] offset_z_o,
  output logic [3:0] neighbor_kind_o,
  output logic [31:0] neighbor_tag_o,
  output logic signed [31:0] neighbor_charge_o,
  output logic overflow_o
);
  import ncl_pkg::*;
  ctrl_t ctrl;
  stat_t stat;
  op_e op;
  reg_e ridx;
  assign op = op_e'(opcode_i);
  assign ridx = reg_e'(cfg_index_i);

  ncl_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .opcode_i(op), .stat_i(stat),
    .busy_o(busy), .ctrl_o(ctrl)
  );

  ncl_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .opcode_i(op),
    .atom_index_i, .atom_tag_i, .atom_kind_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .charge_i, .cfg_we_i, .cfg_index_i(ridx), .cfg_data_i, .ctrl_i(ctrl),
    .stat_o(stat), .valid_o(result_valid_o), .record_kind_o, .list_position_o,
    .neighbor_index_o, .distance_o, .offset_x_o, .offset_y_o, .offset_z_o,
    .neighbor_kind_o, .neighbor_tag_o, .neighbor_charge_o, .overflow_o
  );

  // checks
  `NCL_ASSERT_NEXT(a_emit_strobe, clk_i, rst_ni, ctrl.emit_entry || ctrl.emit_end, result_valid_o, "emit lost")
  `NCL_ASSERT_IMPL(a_emit_excl, clk_i, rst_ni, ctrl.emit_entry, !ctrl.emit_end, "both emits")
  `NCL_ASSERT_NEXT(a_write_idle, clk_i, rst_ni, start && !busy && opcode_i == OP_WRITE, !busy, "write stalled")
endmodule
`default_nettype wire

@@ sv/ncl_sqrt.sv @@
// ----------------------------------------------------------------------------
// ncl_sqrt
// iterative integer square root, two result bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module ncl_sqrt (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [ncl_pkg::DsqBits-1:0] value_i,
  output logic done_o,
  output logic [ncl_pkg::DistBits-1:0] root_o
);
  import ncl_pkg::*;
  localparam int unsigned StepBits = $clog2(DistBits / 2 + 1);

  logic [DsqBits-1:0] rem_q, rem_d;
  logic [DistBits-1:0] root_q, root_d;
  logic [DsqBits-1:0] src_q, src_d;
  logic [StepBits-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;

  // two restoring steps per cycle
  always_comb begin
    logic [DsqBits+1:0] r1, t1;
    logic [DistBits-1:0] q1;
    logic [DsqBits-1:0] s1;
    r1 = '0; t1 = '0; q1 = '0; s1 = '0;
    rem_d = rem_q; root_d = root_q; src_d = src_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      rem_d = '0; root_d = '0; src_d = value_i;
      cnt_d = StepBits'(DistBits / 2); busy_d = 1'b1;
    end else if (busy_q) begin
      r1 = {rem_q, src_q[DsqBits-1 -: 2]};
      t1 = {root_q, 2'b01};
      q1 = {root_q[DistBits-2:0], 1'b0};
      if (r1 >= t1) begin r1 = r1 - t1; q1[0] = 1'b1; end
      s1 = {src_q[DsqBits-3:0], 2'b00};
      t1 = {q1, 2'b01};
      r1 = {r1[DsqBits-1:0], s1[DsqBits-1 -: 2]};
      root_d = {q1[DistBits-2:0], 1'b0};
      if (r1 >= t1) begin r1 = r1 - t1; root_d[0] = 1'b1; end
      rem_d = r1[DsqBits-1:0];
      src_d = {s1[DsqBits-3:0], 2'b00};
      cnt_d = cnt_q - StepBits'(1);
      if (cnt_q == StepBits'(1)) begin busy_d = 1'b0; done_d = 1'b1; end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; root_q <= root_d; src_q <= src_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

@@ sv/ncl_datapath.sv @@
// ----------------------------------------------------------------------------
// ncl_datapath
// atom table, center state, distance arithmetic and result registers
// ----------------------------------------------------------------------------
`default_nettype none
module ncl_datapath #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  ncl_pkg::op_e opcode_i,
  input  logic [11:0] atom_index_i,
  input  logic [31:0] atom_tag_i,
  input  logic [3:0] atom_kind_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] charge_i,
  input  logic cfg_we_i,
  input  ncl_pkg::reg_e cfg_index_i,
  input  logic [ncl_pkg::CutBits-1:0] cfg_data_i,
  input  ncl_pkg::ctrl_t ctrl_i,
  output ncl_pkg::stat_t stat_o,
  output logic valid_o,
  output logic record_kind_o,
  output logic [27:0] list_position_o,
  output logic [11:0] neighbor_index_o,
  output logic [31:0] distance_o,
  output logic signed [31:0] offset_x_o,
  output logic signed [31:0] offset_y_o,
  output logic signed [31:0] offset_z_o,
  output logic [3:0] neighbor_kind_o,
  output logic [31:0] neighbor_tag_o,
  output logic signed [31:0] neighbor_charge_o,
  output logic overflow_o
);
  import ncl_pkg::*;
  localparam int unsigned IdxBits = $clog2(AtomSlots);
  localparam int unsigned DiffBits = COORD_BITS + 1;
  localparam int unsigned SqBits = 2 * DiffBits;
  localparam int unsigned RecBits = 3 * COORD_BITS + 68;

  // atom table, read port loaded when an item is accepted
  logic [RecBits-1:0] mem_q [AtomSlots];
  logic [RecBits-1:0] rd_q;
  logic [IdxBits-1:0] idx;
  assign idx = atom_index_i[IdxBits-1:0];

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_i && opcode_i == OP_WRITE) begin
      mem_q[idx] <= {pos_x_i[COORD_BITS-1:0], pos_y_i[COORD_BITS-1:0],
                     pos_z_i[COORD_BITS-1:0], charge_i, atom_kind_i, atom_tag_i};
    end
    if (start_i && !busy_i) rd_q <= mem_q[idx];
  end

  logic signed [COORD_BITS-1:0] rx, ry, rz;
  logic [31:0] rchg, rtag;
  logic [3:0] rkind;
  assign {rx, ry, rz, rchg, rkind, rtag} = rd_q;

  // configuration and control registers
  logic [CutBits-1:0] cut_q;
  logic [MaxBits-1:0] max_q, cnt_q;
  logic [11:0] cid_q, nidx_q;
  logic ovf_q;
  logic signed [COORD_BITS-1:0] cx_q, cy_q, cz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q <= '0; max_q <= MaxBits'(256); cnt_q <= '0; cid_q <= '0; ovf_q <= 1'b0;
      cx_q <= '0; cy_q <= '0; cz_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_CUTOFF: cut_q <= cfg_data_i;
          REG_MAX:    max_q <= cfg_data_i[MaxBits-1:0];
          default:    ;
        endcase
      end
      if (ctrl_i.latch_center) begin
        cx_q <= rx; cy_q <= ry; cz_q <= rz;
        cnt_q <= '0; ovf_q <= 1'b0; cid_q <= nidx_q;
      end
      if (ctrl_i.count_incr) cnt_q <= cnt_q + MaxBits'(1);
      if (ctrl_i.set_overflow) ovf_q <= 1'b1;
    end
  end

  // operand index capture
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_i) nidx_q <= 12'(idx);
  end

  // offsets and squares
  logic signed [DiffBits-1:0] dx_q, dy_q, dz_q;
  logic [SqBits-1:0] sx_q, sy_q, sz_q;
  logic [DsqBits-1:0] dsq_q;
  logic [COORD_BITS-1:0] mx, my, mz;
  logic [2*COORD_BITS-1:0] px, py, pz;
  logic [SqBits+1:0] tot;
  logic [27:0] lpos;
  logic [31:0] root;
  logic root_done;

  // magnitudes fit in COORD_BITS bits, so each square is COORD_BITS by COORD_BITS
  always_comb begin
    mx = COORD_BITS'(dx_q < 0 ? -dx_q : dx_q);
    my = COORD_BITS'(dy_q < 0 ? -dy_q : dy_q);
    mz = COORD_BITS'(dz_q < 0 ? -dz_q : dz_q);
    px = mx * mx;
    py = my * my;
    pz = mz * mz;
    tot = (SqBits+2)'(sx_q) + (SqBits+2)'(sy_q) + (SqBits+2)'(sz_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sqr) begin
      sx_q <= SqBits'(px); sy_q <= SqBits'(py); sz_q <= SqBits'(pz);
    end else if (!ctrl_i.sum) begin
      dx_q <= DiffBits'(rx) - DiffBits'(cx_q);
      dy_q <= DiffBits'(ry) - DiffBits'(cy_q);
      dz_q <= DiffBits'(rz) - DiffBits'(cz_q);
    end
    if (ctrl_i.sum) begin
      if (tot > (SqBits+2)'({DsqBits{1'b1}})) dsq_q <= '1;
      else dsq_q <= DsqBits'(tot);
    end
  end

  ncl_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(ctrl_i.root_start), .value_i(dsq_q),
    .done_o(root_done), .root_o(root)
  );

  // list slot, kept modulo 2^28
  logic [27:0] prod;
  assign prod = 28'(cid_q) * 28'(max_q) + 28'(cnt_q);
  assign lpos = prod;

  assign stat_o.in_range = dsq_q <= DsqBits'(cut_q);
  assign stat_o.room = cnt_q < max_q;
  assign stat_o.root_done = root_done;

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else valid_o <= ctrl_i.emit_entry | ctrl_i.emit_end;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit_entry || ctrl_i.emit_end) begin
      record_kind_o <= ctrl_i.emit_end;
      list_position_o <= lpos;
      overflow_o <= ctrl_i.emit_end & ovf_q;
      neighbor_index_o <= ctrl_i.emit_end ? '0 : nidx_q;
      distance_o <= ctrl_i.emit_end ? '0 : root;
      offset_x_o <= ctrl_i.emit_end ? '0 : 32'(dx_q);
      offset_y_o <= ctrl_i.emit_end ? '0 : 32'(dy_q);
      offset_z_o <= ctrl_i.emit_end ? '0 : 32'(dz_q);
      neighbor_kind_o <= ctrl_i.emit_end ? '0 : rkind;
      neighbor_tag_o <= ctrl_i.emit_end ? '0 : rtag;
      neighbor_charge_o <= ctrl_i.emit_end ? '0 : rchg;
    end
  end
endmodule
`default_nettype wire

@@ sv/ncl_ctrl.sv @@
// ----------------------------------------------------------------------------
// ncl_ctrl
// sequencer for begin, test and end commands
// ----------------------------------------------------------------------------
`default_nettype none
module ncl_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  ncl_pkg::op_e opcode_i,
  input  ncl_pkg::stat_t stat_i,
  output logic busy_o,
  output ncl_pkg::ctrl_t ctrl_o
);
  import ncl_pkg::*;
  state_e state_q, state_d;
  op_e op_q;

  // opcode capture
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) op_q <= opcode_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i && opcode_i != OP_WRITE) state_d = ST_READ;
      ST_READ: state_d = (op_q == OP_TEST) ? ST_SQR : (op_q == OP_END ? ST_EMIT : ST_IDLE);
      ST_SQR:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_ROOT;
      ST_ROOT: begin
        if (!stat_i.in_range || !stat_i.room) state_d = ST_IDLE;
        else if (stat_i.root_done) state_d = ST_EMIT;
      end
      ST_EMIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  logic root_run_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; root_run_q <= 1'b0;
    end else begin
      state_q <= state_d;
      root_run_q <= (state_q == ST_SUM) ? 1'b0 : (state_q == ST_ROOT);
    end
  end

  // outputs
  always_comb begin
    ctrl_o = '0;
    busy_o = state_q != ST_IDLE;
    unique case (state_q)
      ST_READ: ctrl_o.latch_center = op_q == OP_BEGIN;
      ST_SQR:  ctrl_o.sqr = 1'b1;
      ST_SUM:  ctrl_o.sum = 1'b1;
      ST_ROOT: begin
        ctrl_o.sum = 1'b1;
        ctrl_o.root_start = !root_run_q && stat_i.in_range && stat_i.room;
        ctrl_o.set_overflow = stat_i.in_range && !stat_i.room;
      end
      ST_EMIT: begin
        ctrl_o.sum = 1'b1;
        ctrl_o.emit_entry = op_q == OP_TEST;
        ctrl_o.emit_end = op_q == OP_END;
        ctrl_o.count_incr = op_q == OP_TEST;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
